/* rtl/plv_pkg.sv */
// Package holding the shared types, codes, tables and sizes of the primitive vertex locator.
`timescale 1ns / 1ps
`default_nettype none
package plv_pkg;

    localparam int MAX_INDICES = 4096;
    localparam int IDX_AW      = $clog2(MAX_INDICES);
    localparam int CNT_W       = IDX_AW + 1;
    localparam int MAX_PATCH   = 32;
    localparam int RES_DEPTH   = 32;
    localparam int RES_AW      = $clog2(RES_DEPTH);
    localparam int RES_NW      = RES_AW + 1;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    localparam logic [3:0] TOPO_POINT         = 4'd0;
    localparam logic [3:0] TOPO_LINELIST      = 4'd1;
    localparam logic [3:0] TOPO_LINESTRIP     = 4'd2;
    localparam logic [3:0] TOPO_TRILIST       = 4'd3;
    localparam logic [3:0] TOPO_TRISTRIP      = 4'd4;
    localparam logic [3:0] TOPO_LINELIST_ADJ  = 4'd5;
    localparam logic [3:0] TOPO_LINESTRIP_ADJ = 4'd6;
    localparam logic [3:0] TOPO_TRILIST_ADJ   = 4'd7;
    localparam logic [3:0] TOPO_TRISTRIP_ADJ  = 4'd8;
    localparam logic [3:0] TOPO_PATCHLIST     = 4'd9;

    localparam logic [1:0] IW_NONE = 2'd0;
    localparam logic [1:0] IW_BYTE = 2'd1;
    localparam logic [1:0] IW_HALF = 2'd2;
    localparam logic [1:0] IW_WORD = 2'd3;

    localparam logic [1:0] ROLE_CHOSEN   = 2'd0;
    localparam logic [1:0] ROLE_ADJACENT = 2'd1;
    localparam logic [1:0] ROLE_ACTIVE   = 2'd2;
    localparam logic [1:0] ROLE_INACTIVE = 2'd3;

    localparam logic [2:0] REG_TOPOLOGY     = 3'd0;
    localparam logic [2:0] REG_INDEX_WIDTH  = 3'd1;
    localparam logic [2:0] REG_VERTEX_TOTAL = 3'd2;
    localparam logic [2:0] REG_BASE_VERTEX  = 3'd3;
    localparam logic [2:0] REG_PATCH_SIZE   = 3'd4;

    localparam logic [31:0] RESTART_BYTE = 32'hff;
    localparam logic [31:0] RESTART_HALF = 32'hffff;
    localparam logic [31:0] RESTART_WORD = 32'hffffffff;

    localparam logic [31:0] SHORT_STRIP = 32'd6;

    // Reciprocal of three scaled by 2^33; the product shifted right by 33 is x / 3.
    localparam logic [31:0] RECIP_3 = 32'haaaaaaab;

    typedef enum logic [3:0] {
        LM_NONE, LM_PAIR, LM_TRI, LM_LADJ, LM_TADJ, LM_SSTART, LM_SEND, LM_SMID, LM_PATCH
    } lmode_t;

    typedef enum logic [3:0] {
        S_IDLE, S_RES, S_RES_WAIT, S_SETUP, S_DIV, S_SKIP, S_SKIP_WAIT, S_LIST, S_PATCH,
        S_DRAIN
    } state_t;

    typedef struct packed {
        logic [3:0]  topology;
        logic [1:0]  index_width;
        logic [31:0] vertex_total;
        logic [5:0]  patch_size;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  role;
        logic [31:0] num;
    } res_word_t;

    typedef logic [3:0] sel_t;

    localparam sel_t TADJ_SEL [16] = '{4'd0, 4'd1, 4'd2, 4'd2, 4'd3, 4'd4, 4'd4, 4'd5,
                                       4'd0, 4'd0, 4'd2, 4'd4, 4'd0, 4'd0, 4'd0, 4'd0};
    localparam sel_t SST_SEL  [16] = '{4'd0, 4'd1, 4'd2, 4'd4, 4'd3, 4'd0, 4'd4, 4'd2,
                                       4'd6, 4'd0, 4'd2, 4'd4, 4'd0, 4'd0, 4'd0, 4'd0};
    localparam sel_t SEN_SEL  [16] = '{4'd2, 4'd0, 4'd4, 4'd4, 4'd7, 4'd6, 4'd6, 4'd5,
                                       4'd2, 4'd2, 4'd4, 4'd6, 4'd0, 4'd0, 4'd0, 4'd0};
    localparam sel_t SMD_SEL  [16] = '{4'd0, 4'd2, 4'd4, 4'd2, 4'd5, 4'd6, 4'd6, 4'd8,
                                       4'd4, 4'd2, 4'd4, 4'd6, 4'd0, 4'd0, 4'd0, 4'd0};

    function automatic logic [3:0] list_len(lmode_t m);
        logic [3:0] len;
        unique case (m)
            LM_PAIR:                              len = 4'd2;
            LM_TRI:                               len = 4'd3;
            LM_LADJ:                              len = 4'd6;
            LM_TADJ, LM_SSTART, LM_SEND, LM_SMID: len = 4'd12;
            default:                              len = 4'd0;
        endcase
        return len;
    endfunction

    function automatic sel_t list_sel(lmode_t m, logic [3:0] s);
        sel_t sel;
        unique case (m)
            LM_LADJ:   sel = (s == 4'd4) ? 4'd1 : ((s == 4'd5) ? 4'd2 : s);
            LM_TADJ:   sel = TADJ_SEL[s];
            LM_SSTART: sel = SST_SEL[s];
            LM_SEND:   sel = SEN_SEL[s];
            LM_SMID:   sel = SMD_SEL[s];
            default:   sel = s;
        endcase
        return sel;
    endfunction

    function automatic logic [1:0] list_role(lmode_t m, logic [3:0] s);
        logic [1:0] r;
        unique case (m)
            LM_LADJ:                              r = (s < 4'd4) ? ROLE_ADJACENT : ROLE_ACTIVE;
            LM_TADJ, LM_SSTART, LM_SEND, LM_SMID: r = (s < 4'd9) ? ROLE_ADJACENT : ROLE_ACTIVE;
            default:                              r = ROLE_ACTIVE;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

/* rtl/plv_index_ram.sv */
// Index store: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module plv_index_ram
    import plv_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [IDX_AW-1:0] waddr,
    input  wire logic [31:0]       wdata,
    input  wire logic              re,
    input  wire logic [IDX_AW-1:0] raddr,
    output logic      [31:0]       rdata
);

    logic [31:0] mem [MAX_INDICES];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

/* rtl/plv_result_buf.sv */
// Result buffer holding the words of one query until its valid flag is final.
`timescale 1ns / 1ps
`default_nettype none
module plv_result_buf
    import plv_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [RES_AW-1:0] waddr,
    input  wire res_word_t         wdata,
    input  wire logic              re,
    input  wire logic [RES_AW-1:0] raddr,
    output res_word_t              rdata
);

    res_word_t mem [RES_DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

/* rtl/plv_remainder.sv */
// Radix-2 restoring remainder unit, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module plv_remainder
    import plv_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [31:0] dividend,
    input  wire logic [5:0]  divisor,
    output logic             done,
    output logic [5:0]       rem
);

    logic [31:0] q_reg, q_next;
    logic [5:0]  r_reg, r_next;
    logic [5:0]  d_reg, d_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        run_reg, run_next;
    logic        done_reg, done_next;
    logic [6:0]  trial;

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        trial     = {r_reg, q_reg[31]};
        if (start)
        begin
            q_next   = dividend;
            r_next   = 6'd0;
            d_next   = divisor;
            cnt_next = 5'd0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (trial >= {1'b0, d_reg})
            begin
                trial = trial - {1'b0, d_reg};
            end
            r_next   = trial[5:0];
            q_next   = {q_reg[30:0], 1'b0};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done = done_reg;
    assign rem  = r_reg;

endmodule
`default_nettype wire

/* rtl/plv_query_engine.sv */
// Query sequencer: resolves the chosen vertex and its primitive through the index store.
`timescale 1ns / 1ps
`default_nettype none
module plv_query_engine
    import plv_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [31:0]       highlight,
    input  wire cfg_t              cfg,
    input  wire logic [CNT_W-1:0]  count,
    output logic                   mem_re,
    output logic [IDX_AW-1:0]      mem_raddr,
    input  wire logic [31:0]       mem_rdata,
    output logic                   busy,
    output logic                   strobe,
    output logic [1:0]             role,
    output logic [31:0]            vertex_number,
    output logic                   valid_res,
    output logic                   last
);

    state_t      state_reg, state_next;
    state_t      ret_reg, ret_next;
    lmode_t      mode_reg, mode_next;
    logic [31:0] idx_reg, idx_next;
    logic [31:0] base_reg, base_next;
    logic        valid_reg, valid_next;
    logic [RES_NW-1:0] n_reg, n_next;
    logic [3:0]  slot_reg, slot_next;
    logic [31:0] pos_reg, pos_next;
    logic [1:0]  prole_reg, prole_next;
    logic [31:0] v_reg, v_next;
    logic [32:0] p_reg, p_next;
    logic [32:0] end_reg, end_next;
    logic [2:0]  win_reg, win_next;
    logic [RES_AW-1:0] d_reg, d_next;
    logic        pend_reg, pend_next;
    logic        last_reg, last_next;
    logic        oval_reg, oval_next;

    logic        div_start;
    logic [5:0]  div_divisor;
    logic        div_done;
    logic [5:0]  div_rem;

    logic        buf_we;
    res_word_t   buf_wdata;
    logic        buf_re;
    res_word_t   buf_rdata;

    logic [31:0] count_w;
    logic [31:0] nvt;
    logic [5:0]  dim;
    logic [31:0] rv;
    logic [31:0] even_up;
    logic [31:0] sat_v;
    logic [31:0] div_base;
    sel_t        sel;
    logic [RES_NW-1:0] n_last;
    logic [63:0] prod3;
    logic [31:0] q3;
    logic [31:0] q6;
    logic [31:0] tri_base;
    logic [31:0] tadj_base;

    assign count_w = {{(32 - CNT_W){1'b0}}, count};
    assign nvt     = cfg.vertex_total;
    assign n_last  = n_reg - {{(RES_NW - 1){1'b0}}, 1'b1};

    // Triangle list starts: x / 3 by reciprocal multiplication, x / 6 as half of that.
    assign prod3     = {32'd0, idx_reg} * {32'd0, RECIP_3};
    assign q3        = {1'b0, prod3[63:33]};
    assign q6        = {2'b0, prod3[63:34]};
    assign tri_base  = (q3 << 1) + q3;
    assign tadj_base = (q6 << 2) + (q6 << 1);

    always_comb
    begin
        if (cfg.patch_size == 6'd0)
        begin
            dim = 6'd1;
        end
        else if (cfg.patch_size > 6'(MAX_PATCH))
        begin
            dim = 6'(MAX_PATCH);
        end
        else
        begin
            dim = cfg.patch_size;
        end
    end

    always_comb
    begin
        unique case (cfg.index_width)
            IW_BYTE: rv = RESTART_BYTE;
            IW_HALF: rv = RESTART_HALF;
            default: rv = RESTART_WORD;
        endcase
    end

    plv_remainder u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (idx_reg),
        .divisor  (div_divisor),
        .done     (div_done),
        .rem      (div_rem)
    );

    plv_result_buf u_buf (
        .clk   (clk),
        .we    (buf_we),
        .waddr (n_reg[RES_AW-1:0]),
        .wdata (buf_wdata),
        .re    (buf_re),
        .raddr (d_reg),
        .rdata (buf_rdata)
    );

    assign div_base = idx_reg - {26'd0, div_rem};
    assign even_up  = (idx_reg + 32'd1) & ~32'd1;

    always_comb
    begin
        state_next  = state_reg;
        ret_next    = ret_reg;
        mode_next   = mode_reg;
        idx_next    = idx_reg;
        base_next   = base_reg;
        valid_next  = valid_reg;
        n_next      = n_reg;
        slot_next   = slot_reg;
        pos_next    = pos_reg;
        prole_next  = prole_reg;
        v_next      = v_reg;
        p_next      = p_reg;
        end_next    = end_reg;
        win_next    = win_reg;
        d_next      = d_reg;
        pend_next   = 1'b0;
        last_next   = 1'b0;
        oval_next   = oval_reg;
        div_start   = 1'b0;
        div_divisor = dim;
        mem_re      = 1'b0;
        mem_raddr   = pos_reg[IDX_AW-1:0];
        buf_we      = 1'b0;
        buf_wdata   = '{role: prole_reg, num: pos_reg};
        buf_re      = 1'b0;
        sat_v       = 32'd0;
        sel         = 4'd0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    idx_next   = highlight;
                    valid_next = 1'b1;
                    n_next     = '0;
                    pos_next   = highlight;
                    prole_next = ROLE_CHOSEN;
                    ret_next   = S_SETUP;
                    state_next = S_RES;
                end
            end

            S_RES:
            begin
                if (cfg.index_width == IW_NONE)
                begin
                    buf_wdata  = '{role: prole_reg, num: pos_reg};
                    buf_we     = (n_reg < RES_NW'(RES_DEPTH));
                    state_next = ret_reg;
                end
                else if (pos_reg >= count_w)
                begin
                    buf_wdata  = '{role: prole_reg, num: 32'd0};
                    buf_we     = (n_reg < RES_NW'(RES_DEPTH));
                    valid_next = 1'b0;
                    state_next = ret_reg;
                end
                else
                begin
                    mem_re     = 1'b1;
                    state_next = S_RES_WAIT;
                end
                if (buf_we)
                begin
                    n_next = n_reg + {{(RES_NW - 1){1'b0}}, 1'b1};
                end
            end

            S_RES_WAIT:
            begin
                buf_wdata  = '{role: prole_reg, num: mem_rdata};
                buf_we     = (n_reg < RES_NW'(RES_DEPTH));
                if (buf_we)
                begin
                    n_next = n_reg + {{(RES_NW - 1){1'b0}}, 1'b1};
                end
                state_next = ret_reg;
            end

            S_SETUP:
            begin
                slot_next  = 4'd0;
                state_next = S_LIST;
                unique case (cfg.topology)
                    TOPO_LINELIST:
                    begin
                        mode_next = LM_PAIR;
                        base_next = idx_reg & ~32'd1;
                    end
                    TOPO_TRILIST:
                    begin
                        mode_next = LM_TRI;
                        base_next = tri_base;
                    end
                    TOPO_LINELIST_ADJ:
                    begin
                        mode_next = LM_LADJ;
                        base_next = idx_reg & ~32'd3;
                    end
                    TOPO_TRILIST_ADJ:
                    begin
                        mode_next = LM_TADJ;
                        base_next = tadj_base;
                    end
                    TOPO_PATCHLIST:
                    begin
                        mode_next   = LM_PATCH;
                        div_divisor = dim;
                        div_start   = 1'b1;
                        state_next  = S_DIV;
                    end
                    TOPO_LINESTRIP, TOPO_TRISTRIP, TOPO_LINESTRIP_ADJ:
                    begin
                        if (cfg.topology == TOPO_LINESTRIP)
                        begin
                            mode_next = LM_PAIR;
                            win_next  = 3'd1;
                        end
                        else if (cfg.topology == TOPO_TRISTRIP)
                        begin
                            mode_next = LM_TRI;
                            win_next  = 3'd2;
                        end
                        else
                        begin
                            mode_next = LM_LADJ;
                            win_next  = 3'd3;
                        end
                        sat_v = (idx_reg < {29'd0, win_next}) ? 32'd0
                                : idx_reg - {29'd0, win_next};
                        base_next = sat_v;
                        v_next    = sat_v;
                        p_next    = {1'b0, sat_v};
                        if (cfg.index_width != IW_NONE)
                        begin
                            state_next = S_SKIP;
                        end
                    end
                    TOPO_TRISTRIP_ADJ:
                    begin
                        if (nvt < SHORT_STRIP)
                        begin
                            valid_next = 1'b0;
                            mode_next  = LM_NONE;
                        end
                        else if (idx_reg <= 32'd4 || nvt <= 32'd7)
                        begin
                            mode_next = LM_SSTART;
                            base_next = 32'd0;
                        end
                        else if (idx_reg > nvt - 32'd4)
                        begin
                            mode_next = LM_SEND;
                            base_next = nvt - 32'd8;
                        end
                        else
                        begin
                            mode_next = LM_SMID;
                            win_next  = 3'd6;
                            sat_v     = (even_up < 32'd6) ? 32'd0 : even_up - 32'd6;
                            base_next = sat_v;
                            v_next    = sat_v;
                            p_next    = {1'b0, sat_v};
                            if (cfg.index_width != IW_NONE)
                            begin
                                state_next = S_SKIP;
                            end
                        end
                    end
                    default:
                    begin
                        mode_next = LM_NONE;
                    end
                endcase
            end

            S_DIV:
            begin
                if (div_done)
                begin
                    base_next  = div_base;
                    p_next     = {1'b0, div_base};
                    end_next   = {1'b0, div_base} + {27'd0, dim};
                    slot_next  = 4'd0;
                    state_next = S_LIST;
                end
            end

            S_SKIP:
            begin
                if (v_reg >= count_w || (p_reg[31:0] - v_reg) == {29'd0, win_reg}
                    || p_reg[31:0] >= count_w)
                begin
                    base_next  = v_reg;
                    slot_next  = 4'd0;
                    state_next = S_LIST;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = p_reg[IDX_AW-1:0];
                    state_next = S_SKIP_WAIT;
                end
            end

            S_SKIP_WAIT:
            begin
                if (mem_rdata == rv)
                begin
                    v_next = p_reg[31:0] + 32'd1;
                end
                p_next     = p_reg + 33'd1;
                state_next = S_SKIP;
            end

            S_LIST:
            begin
                if (slot_reg == list_len(mode_reg))
                begin
                    d_next     = '0;
                    state_next = (mode_reg == LM_PATCH) ? S_PATCH : S_DRAIN;
                end
                else
                begin
                    sel = list_sel(mode_reg, slot_reg);
                    if (mode_reg == LM_SSTART && sel == 4'd6)
                    begin
                        // The closing vertex of a short strip start is clamped to the strip end.
                        pos_next = (nvt - 32'd1 < 32'd6) ? nvt - 32'd1 : 32'd6;
                    end
                    else
                    begin
                        pos_next = base_reg + {28'd0, sel};
                    end
                    prole_next = list_role(mode_reg, slot_reg);
                    slot_next  = slot_reg + 4'd1;
                    ret_next   = S_LIST;
                    state_next = S_RES;
                end
            end

            S_PATCH:
            begin
                if (!valid_reg || p_reg[32] || p_reg >= end_reg)
                begin
                    d_next     = '0;
                    state_next = S_DRAIN;
                end
                else
                begin
                    p_next = p_reg + 33'd1;
                    if (p_reg[31:0] != idx_reg)
                    begin
                        pos_next   = p_reg[31:0];
                        prole_next = ROLE_INACTIVE;
                        ret_next   = S_PATCH;
                        state_next = S_RES;
                    end
                end
            end

            S_DRAIN:
            begin
                buf_re    = 1'b1;
                pend_next = 1'b1;
                oval_next = valid_reg;
                last_next = (d_reg == n_last[RES_AW-1:0]);
                if (last_next)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    d_next = d_reg + {{(RES_AW - 1){1'b0}}, 1'b1};
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pend_reg  <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            last_reg  <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ret_reg   <= ret_next;
        mode_reg  <= mode_next;
        idx_reg   <= idx_next;
        base_reg  <= base_next;
        valid_reg <= valid_next;
        n_reg     <= n_next;
        slot_reg  <= slot_next;
        pos_reg   <= pos_next;
        prole_reg <= prole_next;
        v_reg     <= v_next;
        p_reg     <= p_next;
        end_reg   <= end_next;
        win_reg   <= win_next;
        d_reg     <= d_next;
        oval_reg  <= oval_next;
    end

    assign busy          = (state_reg != S_IDLE);
    assign strobe        = pend_reg;
    assign role          = buf_rdata.role;
    assign vertex_number = buf_rdata.num;
    assign valid_res     = oval_reg;
    assign last          = last_reg;

endmodule
`default_nettype wire

/* rtl/primitive_vertex_locator.sv */
// Top level of the primitive vertex locator: registers, index appends and the query engine.
//
//   channel   signals                                      handshake
//   -------   ------------------------------------------   ------------------------
//   config    cfg_we, cfg_index, cfg_wdata                 write when cfg_we high
//   command   opcode, index_value, highlight_vertex        start high, busy low
//   result    role, vertex_number, valid_res, last         res_strobe, one cycle
//
// A clear or an append causes no result word. A query resolves each referenced
// position through the synchronous read port of the index store, each lookup done
// before the next is issued; strip queries first walk the restart window one entry at
// a time, list queries find their primitive start by a mask or a reciprocal multiply,
// and patch queries find theirs with the bit-serial remainder unit.
// The words of a query are buffered and then played out one per cycle, since the
// valid flag carried on each of them is known only when the query has finished.
// Reset clears the control state and the index count; the store itself is not cleared.
// The receiver cannot stall, so a result word is shown for exactly one cycle; the next
// command may be accepted while the last word of a query is still on the ports.
`timescale 1ns / 1ps
`default_nettype none
module primitive_vertex_locator
    import plv_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_wdata,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  opcode,
    input  wire logic [31:0] index_value,
    input  wire logic [31:0] highlight_vertex,
    output logic             res_strobe,
    output logic [1:0]       role,
    output logic [31:0]      vertex_number,
    output logic             valid_res,
    output logic             last
);

    cfg_t              cfg_reg, cfg_next;
    logic [31:0]       base_vertex_reg, base_vertex_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    logic              accept;
    logic              eng_busy;
    logic              q_start;
    logic              app_we;
    logic [31:0]       masked;
    logic [31:0]       adjusted;
    logic [31:0]       sub;
    logic              mem_re;
    logic [IDX_AW-1:0] mem_raddr;
    logic [31:0]       mem_rdata;

    assign accept  = start && !eng_busy;
    assign q_start = accept && (opcode == OP_QUERY);
    assign busy    = eng_busy;

    // Configuration registers; an index beyond the list is ignored.
    always_comb
    begin
        cfg_next         = cfg_reg;
        base_vertex_next = base_vertex_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TOPOLOGY:     cfg_next.topology     = cfg_wdata[3:0];
                REG_INDEX_WIDTH:  cfg_next.index_width  = cfg_wdata[1:0];
                REG_VERTEX_TOTAL: cfg_next.vertex_total = cfg_wdata;
                REG_BASE_VERTEX:  base_vertex_next      = cfg_wdata;
                REG_PATCH_SIZE:   cfg_next.patch_size   = cfg_wdata[5:0];
                default:          cfg_next              = cfg_reg;
            endcase
        end
    end

    // An appended index is masked to the index width, then moved by the base vertex.
    // A negative base saturates at zero; a positive one wraps.
    always_comb
    begin
        unique case (cfg_reg.index_width)
            IW_BYTE: masked = index_value & RESTART_BYTE;
            IW_HALF: masked = index_value & RESTART_HALF;
            default: masked = index_value;
        endcase
        sub = 32'd0 - base_vertex_reg;
        if (base_vertex_reg[31])
        begin
            adjusted = (masked < sub) ? 32'd0 : masked - sub;
        end
        else
        begin
            adjusted = masked + base_vertex_reg;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        app_we     = 1'b0;
        if (accept && opcode == OP_CLEAR)
        begin
            count_next = '0;
        end
        else if (accept && opcode == OP_APPEND && count_reg < CNT_W'(MAX_INDICES))
        begin
            app_we     = 1'b1;
            count_next = count_reg + {{(CNT_W - 1){1'b0}}, 1'b1};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.topology     <= TOPO_POINT;
            cfg_reg.index_width  <= IW_NONE;
            cfg_reg.vertex_total <= 32'd0;
            cfg_reg.patch_size   <= 6'd1;
            base_vertex_reg      <= 32'd0;
            count_reg            <= '0;
        end
        else
        begin
            cfg_reg         <= cfg_next;
            base_vertex_reg <= base_vertex_next;
            count_reg       <= count_next;
        end
    end

    plv_index_ram u_ram (
        .clk   (clk),
        .we    (app_we),
        .waddr (count_reg[IDX_AW-1:0]),
        .wdata (adjusted),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    plv_query_engine u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (q_start),
        .highlight     (highlight_vertex),
        .cfg           (cfg_reg),
        .count         (count_reg),
        .mem_re        (mem_re),
        .mem_raddr     (mem_raddr),
        .mem_rdata     (mem_rdata),
        .busy          (eng_busy),
        .strobe        (res_strobe),
        .role          (role),
        .vertex_number (vertex_number),
        .valid_res     (valid_res),
        .last          (last)
    );

endmodule
`default_nettype wire
